// ----- hdl/stroked_circle_rasterizer_macros.svh -----
// assertion macros shared by the rasterizer modules
// expects signals named clk and arst_n in the module that uses them
`ifndef STROKED_CIRCLE_RASTERIZER_MACROS_SVH
`define STROKED_CIRCLE_RASTERIZER_MACROS_SVH

// same-cycle implication
`define SCR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stroked circle rasterizer: check failed");

// next-cycle implication
`define SCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stroked circle rasterizer: check failed");

`endif

// ----- hdl/scr_pkg.sv -----
// shared types, constants and helpers for the stroked circle rasterizer
// no dependencies
package scr_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;

	localparam int COORD_W    = 13;
	localparam int RADIUS_W   = 10;
	localparam int CELL_W     = 12;
	localparam int SQ_W       = 22;
	localparam int RSQ_W      = 2 * RADIUS_W;
	localparam int COLOR_W    = 32;
	localparam int WEIGHT_W   = 6;
	localparam int PIX_W      = 10;
	localparam int POS_W      = 15;
	localparam int NUM_WRITES = 8;
	localparam int CELL_WRITES = 4;
	localparam int SEL_W      = $clog2(NUM_WRITES);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_FILL_RGB        = 2'd0,
		REG_LINE_RGB        = 2'd1,
		REG_LINE_WIDTH      = 2'd2,
		REG_TRANSPARENT_KEY = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  fill_rgb;
		logic [COLOR_W-1:0]  line_rgb;
		logic [WEIGHT_W-1:0] line_width;
		logic [COLOR_W-1:0]  transparent_key;
	} cfg_t;

	// one accepted word, with the scan state it saw
	typedef struct packed {
		logic                done;
		logic                has_cell;
		logic                has_border;
		logic [CELL_W-1:0]   row;
		logic [CELL_W-1:0]   col;
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [RADIUS_W-1:0] radius;
		logic [SQ_W-1:0]     outer_sq;
		logic [SQ_W-1:0]     inner_sq;
		logic [RSQ_W-1:0]    radius_sq;
	} snap_t;

	// up to eight pixel writes of one word
	typedef struct packed {
		logic                                done;
		logic [NUM_WRITES-1:0]               mask;
		logic [NUM_WRITES-1:0][PIX_W-1:0]    px;
		logic [NUM_WRITES-1:0][PIX_W-1:0]    py;
		logic [COLOR_W-1:0]                  cell_color;
		logic [COLOR_W-1:0]                  border_color;
	} cand_t;

	// ceil(w/2)
	function automatic logic [WEIGHT_W-1:0] half_ceil(input logic [WEIGHT_W-1:0] w);
		logic [WEIGHT_W:0] s;
		s = {1'b0, w} + (WEIGHT_W+1)'(1);
		return s[WEIGHT_W:1];
	endfunction

	// signed position inside [0, limit)
	function automatic logic on_axis(input logic [POS_W-1:0] pos, input int limit);
		return !pos[POS_W-1] && (pos < POS_W'(limit));
	endfunction

endpackage

// ----- hdl/scr_scan.sv -----
// scan sequencer: circle set-up, quadrant cell walk and the first pipeline register
// depends on scr_pkg and the assertion macros
`include "stroked_circle_rasterizer_macros.svh"

module scr_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scr_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  scr_pkg::cmd_t                 in_cmd,
	input  logic [scr_pkg::COORD_W-1:0]   in_cx,
	input  logic [scr_pkg::COORD_W-1:0]   in_cy,
	input  logic [scr_pkg::RADIUS_W-1:0]  in_radius,
	input  logic                          take_s1,
	output logic                          valid_s1,
	output scr_pkg::snap_t                snap_s1
);

	logic                                busy_q;
	logic signed [scr_pkg::CELL_W-1:0]   row_q;
	logic signed [scr_pkg::CELL_W-1:0]   col_q;
	logic signed [scr_pkg::CELL_W-1:0]   start_q;
	logic [scr_pkg::COORD_W-1:0]         cx_q;
	logic [scr_pkg::COORD_W-1:0]         cy_q;
	logic [scr_pkg::RADIUS_W-1:0]        rad_q;
	logic [scr_pkg::SQ_W-1:0]            outer_q;
	logic [scr_pkg::SQ_W-1:0]            inner_q;
	logic [scr_pkg::RSQ_W-1:0]           rsq_q;
	logic                                valid_s1_q;
	scr_pkg::snap_t                      snap_s1_q;

	logic                                accept;
	logic                                stroke_vis;
	logic [scr_pkg::WEIGHT_W-2:0]        half_floor;
	logic signed [scr_pkg::CELL_W-1:0]   init_c;
	logic signed [scr_pkg::CELL_W-1:0]   inner_c;
	logic signed [2*scr_pkg::CELL_W-1:0] outer_p;
	logic signed [2*scr_pkg::CELL_W-1:0] inner_p;
	logic [scr_pkg::RSQ_W-1:0]           rsq_p;
	logic signed [scr_pkg::CELL_W-1:0]   col_inc;
	logic signed [scr_pkg::CELL_W-1:0]   row_inc;
	logic                                wrap;
	logic                                fin;
	logic                                busy_d;
	scr_pkg::snap_t                      snap_d;

	assign in_ready = !valid_s1_q || take_s1;
	assign accept   = in_valid && in_ready;

	// circle set-up terms
	always_comb begin
		stroke_vis = cfg.line_rgb != cfg.transparent_key;
		half_floor = cfg.line_width[scr_pkg::WEIGHT_W-1:1];
		init_c  = -$signed({2'b00, in_radius})
			- (stroke_vis ? $signed({7'b0, half_floor}) : 12'sd0);
		inner_c = $signed({2'b00, in_radius})
			- $signed({6'b0, scr_pkg::half_ceil(cfg.line_width)});
		outer_p = init_c * init_c;
		inner_p = inner_c * inner_c;
		rsq_p   = in_radius * in_radius;
	end

	// cell walk: column inner, row outer
	always_comb begin
		col_inc = col_q + 12'sd1;
		row_inc = row_q + 12'sd1;
		wrap    = col_inc > 12'sd0;
		fin     = wrap && (row_inc > 12'sd0);
	end

	// busy after this word, and the snapshot handed down the pipe
	always_comb begin
		busy_d = busy_q;
		snap_d = '0;
		snap_d.row       = row_q;
		snap_d.col       = col_q;
		snap_d.cx        = cx_q;
		snap_d.cy        = cy_q;
		snap_d.radius    = rad_q;
		snap_d.outer_sq  = outer_q;
		snap_d.inner_sq  = inner_q;
		snap_d.radius_sq = rsq_q;
		if (in_cmd == scr_pkg::CMD_START) begin
			busy_d = 1'b1;
		end else if (busy_q) begin
			if (!start_q[scr_pkg::CELL_W-1]) begin
				busy_d            = 1'b0;
				snap_d.has_border = 1'b1;
			end else begin
				snap_d.has_cell   = 1'b1;
				snap_d.has_border = fin;
				busy_d            = !fin;
			end
		end
		snap_d.done = !busy_d;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			start_q <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			rad_q   <= '0;
			outer_q <= '0;
			inner_q <= '0;
			rsq_q   <= '0;
		end else if (accept) begin
			busy_q <= busy_d;
			if (in_cmd == scr_pkg::CMD_START) begin
				start_q <= init_c;
				row_q   <= init_c + 12'sd1;
				col_q   <= init_c + 12'sd1;
				cx_q    <= in_cx;
				cy_q    <= in_cy;
				rad_q   <= in_radius;
				outer_q <= outer_p[scr_pkg::SQ_W-1:0];
				inner_q <= inner_p[scr_pkg::SQ_W-1:0];
				rsq_q   <= rsq_p;
			end else if (busy_q && start_q[scr_pkg::CELL_W-1]) begin
				col_q <= wrap ? start_q + 12'sd1 : col_inc;
				row_q <= wrap ? row_inc : row_q;
			end
		end
	end

	// first pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1_q <= snap_d;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign snap_s1  = snap_s1_q;

	`SCR_ASSERT_NEXT(a_start_sets_busy, accept && in_cmd == scr_pkg::CMD_START, busy_q)
	`SCR_ASSERT_IMPL(a_col_in_scan, busy_q && start_q[scr_pkg::CELL_W-1], (col_q <= 12'sd0) && (col_q > start_q))

endmodule

// ----- hdl/scr_shade.sv -----
// cell shading: distance squares, ring or interior colour, mirrored and border writes
// depends on scr_pkg and the assertion macros
`include "stroked_circle_rasterizer_macros.svh"

module scr_shade (
	input  logic           clk,
	input  logic           arst_n,
	input  scr_pkg::cfg_t  cfg,
	input  logic           valid_s1,
	input  scr_pkg::snap_t snap_s1,
	output logic           take_s1,
	input  logic           cand_ready,
	output logic           cand_valid,
	output scr_pkg::cand_t cand
);

	logic                                valid_s2_q;
	scr_pkg::snap_t                      snap_s2;
	logic [scr_pkg::SQ_W-1:0]            row_sq_s2;
	logic [scr_pkg::SQ_W-1:0]            col_sq_s2;

	logic signed [2*scr_pkg::CELL_W-1:0] row_p;
	logic signed [2*scr_pkg::CELL_W-1:0] col_p;
	logic [scr_pkg::SQ_W:0]              dsq;
	logic                                stroke_vis;
	logic                                in_outer;
	logic                                in_ring;
	logic [scr_pkg::COLOR_W-1:0]         color;
	logic                                cell_ok;
	logic                                border_ok;
	logic [scr_pkg::POS_W-1:0]           x;
	logic [scr_pkg::POS_W-1:0]           y;
	logic [scr_pkg::POS_W-1:0]           cx_ofs;
	logic [scr_pkg::POS_W-1:0]           cy_ofs;
	logic [scr_pkg::POS_W-1:0]           r_ofs;
	logic [scr_pkg::POS_W-1:0]           wx [scr_pkg::NUM_WRITES];
	logic [scr_pkg::POS_W-1:0]           wy [scr_pkg::NUM_WRITES];

	assign take_s1    = !valid_s2_q || cand_ready;
	assign cand_valid = valid_s2_q;

	// squares of the cell offsets
	always_comb begin
		row_p = $signed(snap_s1.row) * $signed(snap_s1.row);
		col_p = $signed(snap_s1.col) * $signed(snap_s1.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
		end else if (take_s1) begin
			valid_s2_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			snap_s2   <= snap_s1;
			row_sq_s2 <= row_p[scr_pkg::SQ_W-1:0];
			col_sq_s2 <= col_p[scr_pkg::SQ_W-1:0];
		end
	end

	// classify the cell and pick its colour
	always_comb begin
		dsq        = {1'b0, row_sq_s2} + {1'b0, col_sq_s2};
		stroke_vis = cfg.line_rgb != cfg.transparent_key;
		in_outer   = dsq <= {1'b0, snap_s2.outer_sq};
		in_ring    = dsq > {1'b0, snap_s2.inner_sq};
		if (in_ring && (stroke_vis || dsq > {3'b0, snap_s2.radius_sq})) begin
			color = cfg.line_rgb;
		end else begin
			color = cfg.fill_rgb;
		end
		cell_ok   = snap_s2.has_cell && in_outer && (color != cfg.transparent_key);
		border_ok = snap_s2.has_border && stroke_vis;
	end

	// write positions: four mirrors, then four border dots
	always_comb begin
		x      = {{2{snap_s2.cx[scr_pkg::COORD_W-1]}}, snap_s2.cx};
		y      = {{2{snap_s2.cy[scr_pkg::COORD_W-1]}}, snap_s2.cy};
		cx_ofs = {{3{snap_s2.col[scr_pkg::CELL_W-1]}}, snap_s2.col};
		cy_ofs = {{3{snap_s2.row[scr_pkg::CELL_W-1]}}, snap_s2.row};
		r_ofs  = {5'b0, snap_s2.radius}
			- {9'b0, scr_pkg::half_ceil(cfg.line_width)};
		wx[0] = x + cx_ofs;  wy[0] = y + cy_ofs;
		wx[1] = x - cx_ofs;  wy[1] = y + cy_ofs;
		wx[2] = x + cx_ofs;  wy[2] = y - cy_ofs;
		wx[3] = x - cx_ofs;  wy[3] = y - cy_ofs;
		wx[4] = x;           wy[4] = y - r_ofs;
		wx[5] = x;           wy[5] = y + r_ofs;
		wx[6] = x - r_ofs;   wy[6] = y;
		wx[7] = x + r_ofs;   wy[7] = y;
	end

	// candidate writes with their keep mask
	always_comb begin
		cand = '0;
		cand.done         = snap_s2.done;
		cand.cell_color   = color;
		cand.border_color = cfg.line_rgb;
		for (int i = 0; i < scr_pkg::NUM_WRITES; i++) begin
			cand.px[i]   = wx[i][scr_pkg::PIX_W-1:0];
			cand.py[i]   = wy[i][scr_pkg::PIX_W-1:0];
			cand.mask[i] = ((i < scr_pkg::CELL_WRITES) ? cell_ok : border_ok)
				&& scr_pkg::on_axis(wx[i], scr_pkg::SCREEN_WIDTH)
				&& scr_pkg::on_axis(wy[i], scr_pkg::SCREEN_HEIGHT);
		end
	end

	`SCR_ASSERT_IMPL(a_no_cell_no_mirror, valid_s2_q && !snap_s2.has_cell, cand.mask[scr_pkg::CELL_WRITES-1:0] == '0)
	`SCR_ASSERT_IMPL(a_no_border_on_start, valid_s2_q && !snap_s2.done, cand.mask[scr_pkg::NUM_WRITES-1:scr_pkg::CELL_WRITES] == '0)

endmodule

// ----- hdl/scr_out.sv -----
// result buffer: holds one word's writes and hands them out one per cycle while out_ready is high
// depends on scr_pkg and the assertion macros
`include "stroked_circle_rasterizer_macros.svh"

module scr_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cand_valid,
	input  scr_pkg::cand_t               cand,
	output logic                         cand_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         write_valid,
	output logic [scr_pkg::PIX_W-1:0]    pixel_x,
	output logic [scr_pkg::PIX_W-1:0]    pixel_y,
	output logic [scr_pkg::COLOR_W-1:0]  pixel_color,
	output logic                         last,
	output logic                         done_res
);

	logic                                         buf_valid_q;
	logic [scr_pkg::NUM_WRITES-1:0]               mask_q;
	logic                                         done_q;
	logic [scr_pkg::NUM_WRITES-1:0][scr_pkg::PIX_W-1:0] px_q;
	logic [scr_pkg::NUM_WRITES-1:0][scr_pkg::PIX_W-1:0] py_q;
	logic [scr_pkg::COLOR_W-1:0]                  cell_color_q;
	logic [scr_pkg::COLOR_W-1:0]                  border_color_q;

	logic [scr_pkg::SEL_W-1:0]                    sel;
	logic [scr_pkg::NUM_WRITES-1:0]               mask_rest;
	logic                                         pop;

	// lowest pending write goes first
	always_comb begin
		sel = '0;
		for (int i = scr_pkg::NUM_WRITES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = scr_pkg::SEL_W'(i);
			end
		end
		mask_rest = mask_q & (mask_q - scr_pkg::NUM_WRITES'(1));
	end

	assign last       = mask_rest == '0;
	assign pop        = buf_valid_q && out_ready;
	assign cand_ready = !buf_valid_q || (pop && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			mask_q      <= '0;
		end else if (cand_ready) begin
			buf_valid_q <= cand_valid;
			mask_q      <= cand.mask;
		end else if (pop) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_ready && cand_valid) begin
			done_q         <= cand.done;
			px_q           <= cand.px;
			py_q           <= cand.py;
			cell_color_q   <= cand.cell_color;
			border_color_q <= cand.border_color;
		end
	end

	// result word; an empty mask is the single non-write result
	always_comb begin
		out_valid   = buf_valid_q;
		write_valid = |mask_q;
		done_res    = done_q;
		pixel_x     = '0;
		pixel_y     = '0;
		pixel_color = '0;
		if (write_valid) begin
			pixel_x     = px_q[sel];
			pixel_y     = py_q[sel];
			pixel_color = (sel >= scr_pkg::CELL_WRITES) ? border_color_q : cell_color_q;
		end
	end

	`SCR_ASSERT_NEXT(a_pop_drops_one, pop && !last, buf_valid_q && ($countones(mask_q) == $countones($past(mask_q)) - 1))
	`SCR_ASSERT_NEXT(a_done_held, pop && !last, done_q == $past(done_q))

endmodule

// ----- hdl/stroked_circle_rasterizer.sv -----
// Stroked circle rasterizer. A start word latches centre and radius; each step word
// of a running scan walks one cell of the upper-left quadrant and yields up to four
// mirrored pixel writes, the closing step adding up to four outline border dots. A word
// is taken every cycle while the result side keeps up; the result port gives one write
// per cycle while m_tready is high, and a word gives 1 to 8 results. A word passes the
// snapshot register, the squares register and the result buffer before its first result
// is on the port. Configuration is a plain write port, to be used only while no word is
// in flight.
// top level: config registers and stream ports; uses scr_pkg, scr_scan, scr_shade, scr_out

module stroked_circle_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // center_x[12:0], center_y[25:13], radius[35:26], zero
	input  logic [0:0]  s_tuser,  // command[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // pixel_x[9:0], pixel_y[19:10], pixel_color[51:20], zero
	output logic [1:0]  m_tuser,  // write_valid[0], done_res[1]
	output logic        m_tlast
);

	scr_pkg::cfg_t                  cfg_q;
	logic                           valid_s1;
	scr_pkg::snap_t                 snap_s1;
	logic                           take_s1;
	logic                           cand_valid;
	logic                           cand_ready;
	scr_pkg::cand_t                 cand;
	logic                           write_valid;
	logic [scr_pkg::PIX_W-1:0]      pixel_x;
	logic [scr_pkg::PIX_W-1:0]      pixel_y;
	logic [scr_pkg::COLOR_W-1:0]    pixel_color;
	logic                           done_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fill_rgb        <= '0;
			cfg_q.line_rgb        <= '0;
			cfg_q.line_width      <= scr_pkg::WEIGHT_W'(1);
			cfg_q.transparent_key <= '0;
		end else if (cfg_wr_en) begin
			case (scr_pkg::reg_idx_t'(cfg_index))
				scr_pkg::REG_FILL_RGB:        cfg_q.fill_rgb        <= cfg_data;
				scr_pkg::REG_LINE_RGB:        cfg_q.line_rgb        <= cfg_data;
				scr_pkg::REG_LINE_WIDTH:      cfg_q.line_width      <= cfg_data[scr_pkg::WEIGHT_W-1:0];
				scr_pkg::REG_TRANSPARENT_KEY: cfg_q.transparent_key <= cfg_data;
				default: ;
			endcase
		end
	end

	scr_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (scr_pkg::cmd_t'(s_tuser[0])),
		.in_cx     (s_tdata[12:0]),
		.in_cy     (s_tdata[25:13]),
		.in_radius (s_tdata[35:26]),
		.take_s1   (take_s1),
		.valid_s1  (valid_s1),
		.snap_s1   (snap_s1)
	);

	scr_shade u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.valid_s1   (valid_s1),
		.snap_s1    (snap_s1),
		.take_s1    (take_s1),
		.cand_ready (cand_ready),
		.cand_valid (cand_valid),
		.cand       (cand)
	);

	scr_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.cand_valid  (cand_valid),
		.cand        (cand),
		.cand_ready  (cand_ready),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.write_valid (write_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (m_tlast),
		.done_res    (done_res)
	);

	// result word packing
	assign m_tdata = {4'b0, pixel_color, pixel_y, pixel_x};
	assign m_tuser = {done_res, write_valid};

endmodule
